// ===== rtl/core/bfw_pkg.sv =====
// bfw_pkg: widths, command and status codes for the bounded FIFO with watermark.
// No dependencies; compiled first.
`default_nettype none
package bfw_pkg;

  localparam int DATA_W = 32;  // descriptor width on the ports
  localparam int CNT_W  = 7;   // occupancy, capacity and peak counters
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSH_OK   = 3'd0,
    ST_PUSH_FULL = 3'd1,
    ST_POPPED    = 3'd2,
    ST_POP_EMPTY = 3'd3,
    ST_CLEARED   = 3'd4
  } op_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfw_in_if.sv =====
// bfw_in_if: command channel (valid/ready) into the bounded FIFO.
// Depends on bfw_pkg.
`default_nettype none
interface bfw_in_if;
  import bfw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] unit_data;

  modport source (output valid, cmd, unit_data, input ready);
  modport sink   (input valid, cmd, unit_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bfw_out_if.sv =====
// bfw_out_if: result channel (valid/ready) out of the bounded FIFO.
// Depends on bfw_pkg.
`default_nettype none
interface bfw_out_if;
  import bfw_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] op_status;
  logic [DATA_W-1:0] data_out;
  logic [CNT_W-1:0]  removed_count;
  logic [CNT_W-1:0]  occupancy;
  logic              is_full;
  logic              is_empty;
  logic [CNT_W-1:0]  peak_occupancy;
  logic              nonempty_evt;
  logic              nonfull_evt;

  modport source (
    output valid, op_status, data_out, removed_count, occupancy, is_full, is_empty,
           peak_occupancy, nonempty_evt, nonfull_evt,
    input  ready
  );
  modport sink (
    input  valid, op_status, data_out, removed_count, occupancy, is_full, is_empty,
           peak_occupancy, nonempty_evt, nonfull_evt,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/bfw_ram.sv =====
// bfw_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
`default_nettype none
module bfw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bounded_fifo_with_watermark_unit.sv =====
// bounded_fifo_with_watermark_unit: capacity-limited FIFO of descriptors with
// occupancy, peak tracking and event flags. Depends on bfw_pkg, bfw_in_if,
// bfw_out_if and bfw_ram.
//
//   channel   dir  handshake     carries
//   in_chan   in   valid/ready   cmd, unit_data
//   out_chan  out  valid/ready   status, popped data, counts, flags, events
//   cfg_*     in   write enable  capacity_limit
//
// Each item is decoded and all bookkeeping (pointers, count, peak) updates at the
// accept edge; its result is registered and shows in the next cycle, and one item
// per cycle is sustained while results are taken. A pop reads the one-read-one-write
// store at the accept edge and the registered read data lands together with the result.
// Reset is synchronous: queue empty, peak zero, capacity 64; the store is not cleared.
// A stalled result register holds the input off (ready drops) until taken.
`default_nettype none
module bounded_fifo_with_watermark_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ITEM_WIDTH  = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bfw_in_if.sink                         in_chan,
  bfw_out_if.source                      out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [bfw_pkg::CNT_W-1:0] cfg_wdata
);
  import bfw_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  // ---- control state ----
  logic [CNT_W-1:0] cap_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic             out_valid_r;

  // ---- result register (payload, no reset) ----
  op_status_t       status_r, status_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  logic             full_r, full_nxt;
  logic             nne_r, nne_nxt;
  logic             nnf_r, nnf_nxt;

  logic             accept;
  logic             emit;
  logic [CNT_W-1:0] cap_eff;
  logic             was_full;
  logic             ram_we;
  logic             ram_re;
  logic [ITEM_WIDTH-1:0] ram_rdata;

  // result slot frees when empty or being taken this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // capacity saturated to 1..QUEUE_DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_r) > QUEUE_DEPTH) begin
      cap_eff = CNT_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign was_full = (count_r >= cap_eff);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    peak_nxt    = peak_r;
    status_nxt  = ST_PUSH_OK;
    removed_nxt = '0;
    nne_nxt     = 1'b0;
    nnf_nxt     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    emit        = 1'b1;
    case (cmd_t'(in_chan.cmd))
      CMD_PUSH: begin
        if (was_full) begin
          status_nxt = ST_PUSH_FULL;
        end else begin
          status_nxt = ST_PUSH_OK;
          nne_nxt    = (count_r == '0);
          ram_we     = accept;
          tail_nxt   = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          count_nxt  = count_r + 1'b1;
          if (count_nxt > peak_r) begin
            peak_nxt = count_nxt;
          end
        end
      end
      CMD_POP: begin
        if (count_r == '0) begin
          status_nxt = ST_POP_EMPTY;
        end else begin
          status_nxt = ST_POPPED;
          ram_re     = accept;
          head_nxt   = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          count_nxt  = count_r - 1'b1;
          nnf_nxt    = was_full;
        end
      end
      CMD_CLEAR: begin
        status_nxt  = ST_CLEARED;
        removed_nxt = count_r;
        nnf_nxt     = was_full;
        count_nxt   = '0;
        head_nxt    = '0;
        tail_nxt    = '0;
      end
      default: begin
        // unused command: accepted, no state change, no result
        emit = 1'b0;
      end
    endcase
    full_nxt = (count_nxt >= cap_eff);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
        peak_r  <= peak_nxt;
      end
      if (accept) begin
        out_valid_r <= emit;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; occupancy and peak are read straight from the live
  // counters since nothing else moves them while the result waits
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      full_r    <= full_nxt;
      nne_r     <= nne_nxt;
      nnf_r     <= nnf_nxt;
    end
  end

  bfw_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ITEM_WIDTH'(in_chan.unit_data)),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_chan.valid            = out_valid_r;
  assign out_chan.op_status        = status_r;
  assign out_chan.data_out         = (status_r == ST_POPPED) ? DATA_W'(ram_rdata) : '0;
  assign out_chan.removed_count    = removed_r;
  assign out_chan.occupancy        = count_r;
  assign out_chan.is_full          = full_r;
  assign out_chan.is_empty         = (count_r == '0);
  assign out_chan.peak_occupancy   = peak_r;
  assign out_chan.nonempty_evt     = nne_r;
  assign out_chan.nonfull_evt      = nnf_r;

endmodule
`default_nettype wire
